[src/stlb_pkg.sv]
// Shared types, constants and command/status bundles for the lower-bound search block.
package stlb_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int SIZE_W      = 11;
    localparam int IDX_W       = 10;
    localparam int KEY_W       = 32;

    typedef enum logic [0:0] {
        ACT_LOAD  = 1'b0,
        ACT_QUERY = 1'b1
    } t_action;

    typedef struct packed {
        t_action                   action;
        logic        [IDX_W-1:0]   entry_index;
        logic signed [KEY_W-1:0]   entry_value;
        logic signed [KEY_W-1:0]   query_key;
    } t_item;

    typedef struct packed {
        logic                      match_found;
        logic        [SIZE_W-1:0]  match_index;
        logic signed [KEY_W-1:0]   match_value;
    } t_result;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_PROBE,
        S_FETCH
    } t_state;

    typedef enum logic [1:0] {
        RD_CUR,
        RD_NEXT,
        RD_POS
    } t_rd_sel;

    typedef struct packed {
        logic    write_entry;
        logic    load_query;
        logic    step;
        logic    adv_pos;
        logic    emit_hit;
        logic    emit_miss;
        t_rd_sel rd_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic len_gt1;
        logic key_less;
        logic pos_lt_n;
        logic n_zero;
    } t_dp_sts;

    // Probe address for a search window: midpoint while the window is wider than one.
    function automatic logic [ADDR_W-1:0] probe_addr(input logic [ADDR_W-1:0] base,
                                                     input logic [SIZE_W-1:0] len);
        logic [SIZE_W-1:0] half;
        half = len >> 1;
        return (len > SIZE_W'(1)) ? base + half[ADDR_W-1:0] : base;
    endfunction

endpackage

[src/stlb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module stlb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/stlb_ctrl.sv]
// Controller state machine sequencing loads, halving probes and result emission.
module stlb_ctrl import stlb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_action i_action,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '{default: '0, rd_sel: RD_CUR};
        o_busy  = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    if (i_action == ACT_QUERY) begin
                        o_cmd.load_query = 1'b1;
                        n_state          = S_ISSUE;
                    end else begin
                        o_cmd.write_entry = 1'b1;
                    end
                end
            end
            S_ISSUE: begin
                if (i_sts.n_zero) begin
                    o_cmd.emit_miss = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.rd_sel = RD_CUR;
                    n_state      = S_PROBE;
                end
            end
            S_PROBE: begin
                if (i_sts.len_gt1) begin
                    o_cmd.step   = 1'b1;
                    o_cmd.rd_sel = RD_NEXT;
                end else if (!i_sts.key_less) begin
                    o_cmd.emit_hit = 1'b1;
                    n_state        = S_IDLE;
                end else if (i_sts.pos_lt_n) begin
                    o_cmd.adv_pos = 1'b1;
                    o_cmd.rd_sel  = RD_POS;
                    n_state       = S_FETCH;
                end else begin
                    o_cmd.emit_miss = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_FETCH: begin
                o_cmd.emit_hit = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[src/stlb_dp.sv]
// Datapath: table memory, search window registers, size register and result register.
module stlb_dp import stlb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_item             i_item,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_data,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    output logic              o_done,
    output t_result           o_result
);

    logic        [SIZE_W-1:0] r_table_size;
    logic signed [KEY_W-1:0]  r_key;
    logic        [SIZE_W-1:0] r_n;
    logic        [ADDR_W-1:0] r_base;
    logic        [SIZE_W-1:0] r_len;
    logic                     r_done;
    t_result                  r_res;

    logic        [SIZE_W-1:0] n_sat;
    logic        [SIZE_W-1:0] w_half;
    logic        [ADDR_W-1:0] w_mid;
    logic        [ADDR_W-1:0] n_base;
    logic        [SIZE_W-1:0] n_len;
    logic        [ADDR_W-1:0] w_pos;
    logic        [ADDR_W-1:0] w_raddr;
    logic        [KEY_W-1:0]  w_rdata;
    logic                     w_key_less;
    logic                     w_we;

    assign n_sat = (r_table_size > SIZE_W'(TABLE_DEPTH)) ? SIZE_W'(TABLE_DEPTH)
                                                         : r_table_size;

    assign w_half     = r_len >> 1;
    assign w_mid      = r_base + w_half[ADDR_W-1:0];
    assign w_key_less = $signed(w_rdata) < r_key;
    assign n_base     = w_key_less ? w_mid : r_base;
    assign n_len      = r_len - w_half;
    assign w_pos      = r_base + ADDR_W'(1);

    always_comb begin
        case (i_cmd.rd_sel)
            RD_CUR:  w_raddr = probe_addr(r_base, r_len);
            RD_NEXT: w_raddr = probe_addr(n_base, n_len);
            RD_POS:  w_raddr = w_pos;
            default: w_raddr = r_base;
        endcase
    end

    assign w_we = i_cmd.write_entry && (32'(i_item.entry_index) < TABLE_DEPTH);

    stlb_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_item.entry_index[ADDR_W-1:0]),
        .i_wdata (i_item.entry_value),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= SIZE_W'(TABLE_DEPTH);
            r_done       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_table_size <= i_cfg_data;
            end
            r_done <= i_cmd.emit_hit || i_cmd.emit_miss;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query) begin
            r_key  <= i_item.query_key;
            r_n    <= n_sat;
            r_base <= '0;
            r_len  <= n_sat;
        end else if (i_cmd.step) begin
            r_base <= n_base;
            r_len  <= n_len;
        end else if (i_cmd.adv_pos) begin
            r_base <= w_pos;
        end
        if (i_cmd.emit_hit) begin
            r_res.match_found <= 1'b1;
            r_res.match_index <= SIZE_W'(r_base);
            r_res.match_value <= w_rdata;
        end else if (i_cmd.emit_miss) begin
            r_res.match_found <= 1'b0;
            r_res.match_index <= r_n;
            r_res.match_value <= '0;
        end
    end

    assign o_sts.len_gt1  = r_len > SIZE_W'(1);
    assign o_sts.key_less = w_key_less;
    assign o_sts.pos_lt_n = (SIZE_W'(r_base) + SIZE_W'(1)) < r_n;
    assign o_sts.n_zero   = (r_n == '0);

    assign o_done   = r_done;
    assign o_result = r_res;

    a_strobe_spaced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("result strobes in consecutive cycles");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && !r_res.match_found) |-> (r_res.match_value == '0 && r_res.match_index == r_n))
        else $error("miss result not cleared or wrong index");

    a_hit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_res.match_found) |-> (r_res.match_index < r_n))
        else $error("hit index beyond searched size");

    a_step_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_len > SIZE_W'(1) && r_len <= r_n))
        else $error("halving step on a collapsed window");

endmodule

[src/sorted_table_lower_bound.sv]
// Top level of the sorted-table lower-bound search block.
//
//  channel   | ports                                    | handshake
//  ----------+------------------------------------------+----------------------------
//  item in   | start, busy, i_item                      | taken when start && !busy
//  result    | o_done, o_result                         | one-cycle strobe, no stall
//  config    | i_cfg_valid, o_cfg_ready, i_cfg_data     | taken when valid && ready
//
// A load item is taken in the idle state. A query searches n = min(table_size, depth) entries;
// busy covers the issue read, the halving probes and, when the answer sits just past the last
// probe, a fetch of the next entry; the table gives one registered read per cycle. The result
// strobe comes in the cycle after the last busy cycle. Reset leaves the table contents as they
// were and sets table_size to the full depth; results are never held off.
module sorted_table_lower_bound import stlb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_item             i_item,
    output logic              o_done,
    output t_result           o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [SIZE_W-1:0] i_cfg_data
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_busy;

    stlb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_item.action),
        .i_sts    (w_sts),
        .o_cmd    (w_cmd),
        .o_busy   (w_busy)
    );

    stlb_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_valid && !w_busy),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_done     (o_done),
        .o_result   (o_result)
    );

    assign busy        = w_busy;
    assign o_cfg_ready = !w_busy;

endmodule
